// ----- src/sddw_pkg.sv -----
package sddw_pkg;

  localparam int DIGITS  = 8;
  localparam int VALUE_W = 28;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 8;

  localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;

  function automatic longint unsigned pow10(int e);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < e; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // magnitude bits for any displayable number
  localparam int MAG_W = $clog2(pow10(DIGITS));

  localparam logic [VALUE_W-1:0] LIMIT_POS = VALUE_W'(pow10(DIGITS));
  localparam logic [VALUE_W-1:0] LIMIT_NEG = VALUE_W'(pow10(DIGITS - 1));

  // clear sequence: four control writes, then one blank per digit
  localparam int CLR_LEN = 4 + DIGITS;
  localparam int CNT_W   = $clog2(CLR_LEN);

  localparam logic [CNT_W-1:0] STEP_TEST   = CNT_W'(0);
  localparam logic [CNT_W-1:0] STEP_SCAN   = CNT_W'(1);
  localparam logic [CNT_W-1:0] STEP_DECODE = CNT_W'(2);
  localparam logic [CNT_W-1:0] STEP_ON     = CNT_W'(3);

  localparam logic [ADDR_W-1:0] REG_DECODE   = 4'h9;
  localparam logic [ADDR_W-1:0] REG_SCAN     = 4'hB;
  localparam logic [ADDR_W-1:0] REG_SHUTDOWN = 4'hC;
  localparam logic [ADDR_W-1:0] REG_TEST     = 4'hF;

  localparam logic [DATA_W-1:0] CODE_BLANK  = 8'h0F;
  localparam logic [DATA_W-1:0] CODE_MINUS  = 8'h0A;
  localparam logic [DATA_W-1:0] DECODE_ALL  = 8'hFF;
  localparam logic [DATA_W-1:0] TEST_OFF    = 8'h00;
  localparam logic [DATA_W-1:0] DISPLAY_ON  = 8'h01;
  localparam logic [DATA_W-1:0] SCAN_LIMIT  = DATA_W'(DIGITS - 1);

  // ceil(2^35 / 10), exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
  localparam int          RECIP_SH = 35;

  typedef struct packed {
    logic             err;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } job_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  function automatic wr_t clear_step(logic [CNT_W-1:0] idx);
    wr_t w;
    case (idx)
      STEP_TEST: begin
        w.addr = REG_TEST;
        w.data = TEST_OFF;
      end
      STEP_SCAN: begin
        w.addr = REG_SCAN;
        w.data = SCAN_LIMIT;
      end
      STEP_DECODE: begin
        w.addr = REG_DECODE;
        w.data = DECODE_ALL;
      end
      STEP_ON: begin
        w.addr = REG_SHUTDOWN;
        w.data = DISPLAY_ON;
      end
      default: begin
        // blanks go from the top digit down to digit 1
        w.addr = ADDR_W'(DIGITS + 4) - ADDR_W'(idx);
        w.data = CODE_BLANK;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/sddw_front.sv -----
module sddw_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sddw_pkg::VALUE_W-1:0]  in_value,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output sddw_pkg::job_t                       push_job
);
  import sddw_pkg::*;

  logic               fr_valid_r, fr_valid_nxt;
  job_t               fr_job_r, fr_job_nxt;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag_full;
  logic               neg;
  logic               in_fire;

  assign in_ready   = !fr_valid_r || push_ready;
  assign in_fire    = in_valid && in_ready;
  assign push_valid = fr_valid_r;
  assign push_job   = fr_job_r;

  always_comb begin
    raw      = in_value;
    neg      = raw[VALUE_W-1];
    mag_full = neg ? (VALUE_W'(0) - raw) : raw;
    fr_job_nxt.neg = neg;
    // the minus sign takes one digit position of its own
    fr_job_nxt.err = neg ? (mag_full >= LIMIT_NEG) : (mag_full >= LIMIT_POS);
    fr_job_nxt.mag = mag_full[MAG_W-1:0];
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (in_fire) begin
      fr_valid_nxt = 1'b1;
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fr_job_r <= fr_job_nxt;
    end
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

endmodule

// ----- src/sddw_fifo.sv -----
module sddw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sddw_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sddw_pkg::job_t pop_job
);
  import sddw_pkg::*;

  // depth must stay a power of two so the pointers wrap by themselves
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  job_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_fire, pop_fire;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != QCNT_W'(0));
  assign pop_job    = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_fire  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- src/sddw_back.sv -----
module sddw_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  sddw_pkg::job_t                    pop_job,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sddw_pkg::ADDR_W-1:0]       out_addr,
  output logic [sddw_pkg::DATA_W-1:0]       out_data,
  output logic                              out_err,
  output logic                              out_last
);
  import sddw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_DIGIT,
    S_MINUS
  } state_t;

  localparam int Q_W = MAG_W + 32 - RECIP_SH;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_last_r, out_last_nxt;

  logic                  adv;
  logic [MAG_W+31:0]     prod;
  logic [Q_W-1:0]        quo;
  logic [3:0]            quo_lo;
  logic [3:0]            rem;
  logic                  quo_zero;
  wr_t                   clr_first, clr_cur;

  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = (state_r == S_IDLE) && adv;

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_data  = out_data_r;
  assign out_err   = out_err_r;
  assign out_last  = out_last_r;

  // divide by ten with a reciprocal; remainder fits in four bits
  assign prod     = (MAG_W + 32)'(mag_r) * (MAG_W + 32)'(RECIP10);
  assign quo      = prod[MAG_W+31:RECIP_SH];
  assign quo_lo   = 4'(quo);
  assign rem      = mag_r[3:0] - ((quo_lo << 3) + (quo_lo << 1));
  assign quo_zero = (quo == '0);

  assign clr_first = clear_step(STEP_TEST);
  assign clr_cur   = clear_step(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    out_valid_nxt = adv ? 1'b0 : out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid && adv) begin
          out_valid_nxt = 1'b1;
          if (pop_job.err) begin
            out_addr_nxt = '0;
            out_data_nxt = '0;
            out_err_nxt  = 1'b1;
            out_last_nxt = 1'b1;
          end else begin
            out_addr_nxt = clr_first.addr;
            out_data_nxt = clr_first.data;
            out_err_nxt  = 1'b0;
            out_last_nxt = 1'b0;
            mag_nxt      = pop_job.mag;
            neg_nxt      = pop_job.neg;
            cnt_nxt      = CNT_W'(1);
            pos_nxt      = ADDR_W'(1);
            state_nxt    = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = clr_cur.addr;
          out_data_nxt  = clr_cur.data;
          out_err_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(CLR_LEN - 1)) begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = pos_r;
          out_data_nxt  = DATA_W'(rem);
          out_err_nxt   = 1'b0;
          out_last_nxt  = quo_zero && !neg_r;
          mag_nxt       = MAG_W'(quo);
          pos_nxt       = pos_r + ADDR_W'(1);
          if (quo_zero) begin
            state_nxt = neg_r ? S_MINUS : S_IDLE;
          end
        end
      end
      S_MINUS: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = pos_r;
          out_data_nxt  = CODE_MINUS;
          out_err_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    pos_r      <= pos_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r)
    else $error("error item not marked last");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> state_r == S_CLEAR || (out_err_r && out_valid_r))
    else $error("job taken but no clear sequence or error started");

  a_digit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIGIT |-> pos_r >= ADDR_W'(1) && pos_r <= ADDR_W'(DIGITS))
    else $error("digit position out of range");

  a_minus_neg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MINUS |-> neg_r)
    else $error("minus write for a positive number");

endmodule

// ----- src/signed_decimal_display_writer.sv -----
// Turns one signed number into the register writes for an 8-digit code-B
// seven-segment display controller.
// in_ channel: one item carries the value (28-bit two's complement).
// out_ channel: one item per register write; tdata holds address and data,
// tuser flags an out-of-range value, tlast marks the final item of a number.
// Each number gives the clear sequence (test off, scan limit, decode all,
// display on, blank to every digit from the top down), then its decimal
// digits from digit 1 upward, then a minus code above the top digit if
// negative: 13 to 20 items. A number too wide for the display gives one
// item with tuser set and no writes.
// The first item of a number passes the front register, the job queue and the
// output register before it is presented. The back sequencer sends one write
// per cycle while out_tready is high; that sequencer sets the rate.
// A two-entry job queue and the front register let up to three further
// numbers be taken while a sequence is still going out.
// Reset (rst_n low, synchronous) empties the queue and drops any item in
// flight. When the receiver holds out_tready low the output item holds and
// the sequencer waits; the input side keeps accepting until the queue fills.
module signed_decimal_display_writer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sddw_pkg::IN_TDATA_W-1:0]     in_tdata,   // value[27:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sddw_pkg::OUT_TDATA_W-1:0]    out_tdata,  // reg_addr[3:0], reg_data[11:4]
  output logic                                out_tuser,  // error
  output logic                                out_tlast
);
  import sddw_pkg::*;

  logic                      push_valid, push_ready;
  logic                      pop_valid, pop_ready;
  job_t                      push_job, pop_job;
  logic signed [VALUE_W-1:0] value;
  logic [ADDR_W-1:0]         reg_addr;
  logic [DATA_W-1:0]         reg_data;

  assign value = signed'(in_tdata[VALUE_W-1:0]);
  assign out_tdata = {{(OUT_TDATA_W - ADDR_W - DATA_W){1'b0}}, reg_data, reg_addr};

  sddw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sddw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  sddw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (reg_addr),
    .out_data  (reg_data),
    .out_err   (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

// ----- verif/tb_signed_decimal_display_writer.sv -----
`timescale 1ns / 100ps

typedef struct packed {
  logic [3:0] addr;
  logic [7:0] data;
  logic       err;
  logic       last;
} display_write_t;

class display_write_board;
  localparam logic [3:0] ADDR_TEST     = 4'hF;
  localparam logic [3:0] ADDR_SCAN     = 4'hB;
  localparam logic [3:0] ADDR_DECODE   = 4'h9;
  localparam logic [3:0] ADDR_SHUTDOWN = 4'hC;
  localparam logic [7:0] BLANK_CODE    = 8'h0F;
  localparam logic [7:0] MINUS_CODE    = 8'h0A;

  display_write_t pending_writes[$];
  int mismatches = 0;

  static function int unsigned ten_to(int e);
    int unsigned p;
    p = 1;
    for (int i = 0; i < e; i++) p = p * 10;
    return p;
  endfunction

  function void push_write(logic [3:0] addr, logic [7:0] data);
    display_write_t w;
    w.addr = addr;
    w.data = data;
    w.err  = 1'b0;
    w.last = 1'b0;
    pending_writes.push_back(w);
  endfunction

  // works out every register write one accepted value causes
  function void note_value(logic [27:0] raw);
    bit             neg;
    int unsigned    mag;
    int unsigned    lim;
    int             pos;
    display_write_t w;
    neg = raw[27];
    mag = neg ? (32'h1000_0000 - {4'h0, raw}) : {4'h0, raw};
    // the minus sign takes one digit position of its own
    lim = neg ? ten_to(sddw_pkg::DIGITS - 1) : ten_to(sddw_pkg::DIGITS);
    if (mag >= lim) begin
      w.addr = '0;
      w.data = '0;
      w.err  = 1'b1;
      w.last = 1'b1;
      pending_writes.push_back(w);
      return;
    end
    push_write(ADDR_TEST, 8'h00);
    push_write(ADDR_SCAN, 8'(sddw_pkg::DIGITS - 1));
    push_write(ADDR_DECODE, 8'hFF);
    push_write(ADDR_SHUTDOWN, 8'h01);
    for (pos = sddw_pkg::DIGITS; pos >= 1; pos--) push_write(4'(pos), BLANK_CODE);
    if (mag == 0) begin
      push_write(4'd1, 8'd0);
    end else begin
      pos = 0;
      while (mag != 0) begin
        pos++;
        push_write(4'(pos), 8'(mag % 10));
        mag = mag / 10;
      end
      if (neg) push_write(4'(pos + 1), MINUS_CODE);
    end
    pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  function void check_write(logic [15:0] tdata, logic err, logic last);
    display_write_t got;
    display_write_t want;
    got.addr = tdata[3:0];
    got.data = tdata[11:4];
    got.err  = err;
    got.last = last;
    if (pending_writes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected write: addr %h data %h err %b last %b",
                 got.addr, got.data, got.err, got.last);
      return;
    end
    want = pending_writes.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("write mismatch: expected addr/data/err/last %h %h %b %b, got %h %h %b %b",
                 want.addr, want.data, want.err, want.last,
                 got.addr, got.data, got.err, got.last);
    end
  endfunction

  function int outstanding();
    return pending_writes.size();
  endfunction
endclass

module tb_signed_decimal_display_writer;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [sddw_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [sddw_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                              out_tuser;
  logic                              out_tlast;

  display_write_board board = new();
  bit steady_in  = 1'b0;
  bit steady_out = 1'b0;
  int hold_left  = 0;
  int stall_cycles = 0;

  signed_decimal_display_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // receiver: random back-pressure, or a long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady_out || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_value(in_tdata[27:0]);
      if (out_tvalid && out_tready) board.check_write(16'(out_tdata), out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_signed_decimal_display_writer: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_value(input logic [27:0] v);
    @(negedge clk);
    while (!steady_in && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sddw_pkg::IN_TDATA_W'(v);
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering, then wait until every expected result has come
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [27:0] pick_value();
    int          r;
    int          ndig;
    bit          neg;
    int unsigned mag;
    r = $urandom_range(99);
    if (r < 80) begin
      // displayable number with a random digit count
      neg  = $urandom_range(1);
      ndig = $urandom_range(1, neg ? sddw_pkg::DIGITS - 1 : sddw_pkg::DIGITS);
      mag  = $urandom_range(board.ten_to(ndig) - 1,
                            ndig == 1 ? 0 : board.ten_to(ndig - 1));
    end else if (r < 90) begin
      // too wide for the display but within the field
      neg = $urandom_range(1);
      mag = neg ? $urandom_range(32'h0800_0000, board.ten_to(7))
                : $urandom_range(32'h07FF_FFFF, board.ten_to(8));
    end else begin
      return 28'($urandom);
    end
    return neg ? 28'(0) - 28'(mag) : 28'(mag);
  endfunction

  initial begin
    logic [27:0] corner_values[$];
    corner_values = '{28'd0, 28'd1, -28'sd1, 28'd5, 28'd9, 28'd10, -28'sd10, 28'd1000,
                      28'd99999999, 28'd100000000, 28'd9999999, -28'sd9999999,
                      -28'sd10000000, 28'd10000000, 28'h7FFFFFF, 28'h8000000,
                      28'd12345678, -28'sd1234567, 28'd10203040, -28'sd1000000,
                      -28'sd9, 28'd50505050, 28'd7};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (corner_values[i]) send_value(corner_values[i]);

    // receiver stalls long while the sender keeps offering, so the input backs up
    hold_left = LONG_HOLD;
    repeat (12) send_value(pick_value());
    wait_drained();

    // a stretch with no idling on either side
    steady_in  = 1'b1;
    steady_out = 1'b1;
    repeat (60) send_value(pick_value());
    steady_in  = 1'b0;
    steady_out = 1'b0;

    repeat (90) send_value(pick_value());
    wait_drained();
    repeat (100) send_value(pick_value());

    wait_drained();
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("tb_signed_decimal_display_writer: clean");
    end else begin
      $display("tb_signed_decimal_display_writer: errors");
    end
    $finish;
  end

endmodule
